[hw/rtl/dataflow_firing_scheduler_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the dataflow firing scheduler
// Concurrent assertion wrappers that fold away in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef DATAFLOW_FIRING_SCHEDULER_CORE_MACROS_SVH
`define DATAFLOW_FIRING_SCHEDULER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Checked only while out of reset.
`define DFS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("dfs assertion failed");

// Checked at every edge, reset included.
`define DFS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("dfs assertion failed");

`else

`define DFS_ASSERT(lbl, clk, rst_n, prop)
`define DFS_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

[hw/rtl/dfs_pkg.sv]
// ----------------------------------------------------------------------------
// dfs_pkg
// Types, constants and edge descriptor helpers of the firing scheduler.
// ----------------------------------------------------------------------------
package dfs_pkg;

  localparam int ACTOR_COUNT = 8;
  localparam int EDGE_COUNT  = 7;
  localparam int MAX_REPEAT  = 16;

  localparam int ACTOR_W     = 3;
  localparam int RATE_W      = 4;
  localparam int DESC_W      = 14;
  localparam int TOKEN_W     = 8;
  localparam int FIRED_W     = 4;
  localparam int REP_FIELD_W = 5;
  localparam int REPS_W      = 40;
  localparam int LEFT_W      = $clog2(MAX_REPEAT + 1);

  localparam int PDATA_W     = 64;
  localparam int PADDR_W     = 6;
  localparam int REG_IDX_W   = 3;

  // Register indexes: edges occupy 0 .. EDGE_COUNT-1
  localparam logic [REG_IDX_W-1:0] REG_REPEAT = 3'd7;

  typedef enum logic [1:0] {
    ST_FIRED    = 2'd0,
    ST_BLOCKED  = 2'd1,
    ST_COMPLETE = 2'd2,
    ST_RESTART  = 2'd3
  } status_e;

  typedef logic [EDGE_COUNT-1:0][DESC_W-1:0]   edge_descs_t;
  typedef logic [EDGE_COUNT-1:0][TOKEN_W-1:0]  tokens_t;
  typedef logic [ACTOR_COUNT-1:0][LEFT_W-1:0]  left_t;
  typedef logic [ACTOR_COUNT-1:0][FIRED_W-1:0] fired_t;

  typedef struct packed {
    status_e              status;
    logic [ACTOR_W-1:0]   actor;
    logic [FIRED_W-1:0]   firing_index;
  } fire_result_t;

  localparam edge_descs_t EDGE_DESC_RESET = {
    14'd1150, 14'd2165, 14'd2156, 14'd1123, 14'd2138, 14'd1105, 14'd2120
  };
  localparam logic [REPS_W-1:0] REPS_RESET = 40'd35504922896;

  function automatic logic [ACTOR_W-1:0] edge_src(input logic [DESC_W-1:0] d);
    return d[2:0];
  endfunction

  function automatic logic [ACTOR_W-1:0] edge_dst(input logic [DESC_W-1:0] d);
    return d[5:3];
  endfunction

  function automatic logic [RATE_W-1:0] edge_prod(input logic [DESC_W-1:0] d);
    return d[9:6];
  endfunction

  function automatic logic [RATE_W-1:0] edge_cons(input logic [DESC_W-1:0] d);
    return d[13:10];
  endfunction

endpackage

[hw/rtl/dataflow_firing_scheduler_core.sv]
// ----------------------------------------------------------------------------
// dataflow_firing_scheduler_core
// Synchronous-dataflow firing scheduler, downstream-first list order, with
// graph description held in APB registers.
// ----------------------------------------------------------------------------
//   port group   direction  handshake              payload
//   in           receive    in_valid_i/in_stall_o  restart_i
//   out          send       out_valid_o/out_stall_i status_o, actor_o,
//                                                  firing_index_o
//   apb          receive    psel/penable/pready    paddr, pwdata, prdata
//
// One item per cycle while the result is not stalled; each item waits in
// the item register and then lands in the result register.
// The firing decision and token update are one combinational pass.
// Reset clears tokens and firings left, so the block reports complete
// until the first restart. A stalled result holds the item register; a new
// item is still taken while the item register is empty.
// ----------------------------------------------------------------------------
`include "dataflow_firing_scheduler_core_macros.svh"

module dataflow_firing_scheduler_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        restart_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [2:0]  actor_o,
  output logic [3:0]  firing_index_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import dfs_pkg::*;

  edge_descs_t         edge_desc_q;
  logic [REPS_W-1:0]   reps_q;
  tokens_t             tokens_q, tokens_d;
  left_t               left_q, left_d;
  fired_t              fired_q, fired_d;
  logic                s1_valid_q, s1_restart_q;
  logic                out_valid_q;
  fire_result_t        out_result_q, fire_res;
  logic                any_left;
  logic                s1_adv, in_accept, cfg_wr;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:PADDR_W-REG_IDX_W];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_REPEAT) begin
      prdata = {{(PDATA_W-REPS_W){1'b0}}, reps_q};
    end else if (reg_idx < REG_IDX_W'(EDGE_COUNT)) begin
      prdata = {{(PDATA_W-DESC_W){1'b0}}, edge_desc_q[reg_idx]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_desc_q <= EDGE_DESC_RESET;
      reps_q      <= REPS_RESET;
    end else if (cfg_wr) begin
      if (reg_idx == REG_REPEAT) begin
        reps_q <= pwdata[REPS_W-1:0];
      end else if (reg_idx < REG_IDX_W'(EDGE_COUNT)) begin
        edge_desc_q[reg_idx] <= pwdata[DESC_W-1:0];
      end
    end
  end

  // Item register advances when the result register is free or draining
  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  dfs_fire_unit u_fire (
    .restart_i   (s1_restart_q),
    .edge_desc_i (edge_desc_q),
    .reps_i      (reps_q),
    .tokens_i    (tokens_q),
    .left_i      (left_q),
    .fired_i     (fired_q),
    .tokens_o    (tokens_d),
    .left_o      (left_d),
    .fired_o     (fired_d),
    .result_o    (fire_res),
    .any_left_o  (any_left)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      tokens_q    <= '0;
      left_q      <= '0;
      fired_q     <= '0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
        tokens_q    <= tokens_d;
        left_q      <= left_d;
        fired_q     <= fired_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_restart_q <= restart_i;
    end
    if (s1_adv) begin
      out_result_q <= fire_res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_result_q.status;
  assign actor_o        = out_result_q.actor;
  assign firing_index_o = out_result_q.firing_index;

  `DFS_ASSERT(a_restart_clears_fired, clk_i, rst_ni, s1_adv && s1_restart_q |=> fired_q == '0)
  `DFS_ASSERT(a_idle_keeps_tokens, clk_i, rst_ni, s1_adv && !s1_restart_q && fire_res.status != ST_FIRED |=> $stable(tokens_q))
  `DFS_ASSERT(a_complete_only_empty, clk_i, rst_ni, s1_valid_q && !s1_restart_q && any_left |-> fire_res.status != ST_COMPLETE)
  `DFS_ASSERT_ALWAYS(a_empty_takes_item, clk_i, !s1_valid_q |-> !in_stall_o)

endmodule

[hw/rtl/dfs_fire_unit.sv]
// ----------------------------------------------------------------------------
// dfs_fire_unit
// Single-pass firing decision: restart reload, enable test of all actors,
// downstream-first pick, token and firing counter update.
// ----------------------------------------------------------------------------
module dfs_fire_unit (
  input  logic                 restart_i,
  input  dfs_pkg::edge_descs_t edge_desc_i,
  input  logic [39:0]          reps_i,
  input  dfs_pkg::tokens_t     tokens_i,
  input  dfs_pkg::left_t       left_i,
  input  dfs_pkg::fired_t      fired_i,
  output dfs_pkg::tokens_t     tokens_o,
  output dfs_pkg::left_t       left_o,
  output dfs_pkg::fired_t      fired_o,
  output dfs_pkg::fire_result_t result_o,
  output logic                 any_left_o
);
  import dfs_pkg::*;

  logic [ACTOR_COUNT-1:0] enable;
  logic                   found;
  logic [ACTOR_W-1:0]     sel;

  // Enable test: firings left and enough tokens on every input edge
  always_comb begin
    for (int a = 0; a < ACTOR_COUNT; a++) begin
      enable[a] = (left_i[a] != '0);
      for (int e = 0; e < EDGE_COUNT; e++) begin
        if (edge_dst(edge_desc_i[e]) == ACTOR_W'(a) &&
            tokens_i[e] < {{(TOKEN_W-RATE_W){1'b0}}, edge_cons(edge_desc_i[e])}) begin
          enable[a] = 1'b0;
        end
      end
    end
  end

  // Highest-numbered enabled actor wins
  always_comb begin
    found = 1'b0;
    sel   = '0;
    for (int a = 0; a < ACTOR_COUNT; a++) begin
      if (enable[a]) begin
        found = 1'b1;
        sel   = ACTOR_W'(a);
      end
    end
  end

  always_comb begin
    any_left_o = 1'b0;
    for (int a = 0; a < ACTOR_COUNT; a++) begin
      if (left_i[a] != '0) begin
        any_left_o = 1'b1;
      end
    end
  end

  always_comb begin
    logic [TOKEN_W-1:0]     tok;
    logic [TOKEN_W:0]       sum;
    logic [REP_FIELD_W-1:0] q;

    tokens_o = tokens_i;
    left_o   = left_i;
    fired_o  = fired_i;
    result_o = '{status: ST_BLOCKED, actor: '0, firing_index: '0};
    tok      = '0;
    sum      = '0;
    q        = '0;

    if (restart_i) begin
      tokens_o = '0;
      fired_o  = '0;
      for (int a = 0; a < ACTOR_COUNT; a++) begin
        q = reps_i[REP_FIELD_W*a +: REP_FIELD_W];
        // clamp the reload so the firing number fits its field
        left_o[a] = (q > REP_FIELD_W'(MAX_REPEAT)) ? LEFT_W'(MAX_REPEAT) : LEFT_W'(q);
      end
      result_o.status = ST_RESTART;
    end else if (!any_left_o) begin
      result_o.status = ST_COMPLETE;
    end else if (found) begin
      for (int e = 0; e < EDGE_COUNT; e++) begin
        tok = tokens_i[e];
        // consume before produce so self loops behave
        if (edge_dst(edge_desc_i[e]) == sel) begin
          tok = tok - {{(TOKEN_W-RATE_W){1'b0}}, edge_cons(edge_desc_i[e])};
        end
        if (edge_src(edge_desc_i[e]) == sel) begin
          sum = {1'b0, tok} + {{(TOKEN_W+1-RATE_W){1'b0}}, edge_prod(edge_desc_i[e])};
          tok = sum[TOKEN_W] ? {TOKEN_W{1'b1}} : sum[TOKEN_W-1:0];
        end
        tokens_o[e] = tok;
      end
      fired_o[sel]          = fired_i[sel] + FIRED_W'(1);
      left_o[sel]           = left_i[sel] - LEFT_W'(1);
      result_o.status       = ST_FIRED;
      result_o.actor        = sel;
      result_o.firing_index = fired_i[sel];
    end
  end

endmodule

[tb/tb_dataflow_firing_scheduler_core.sv]
// ----------------------------------------------------------------------------
// Testbench for the dataflow firing scheduler core
// Programs graphs over APB, streams restart and next-firing requests with
// random sender gaps and receiver stalls, and checks every result against a
// cycle-free schedule predictor kept in a small scoreboard.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_dataflow_firing_scheduler_core;

  import dfs_pkg::*;

  class firing_scoreboard;
    logic [DESC_W-1:0]  desc   [EDGE_COUNT];
    logic [REPS_W-1:0]  reps;
    logic [TOKEN_W-1:0] tokens [EDGE_COUNT];
    logic [LEFT_W-1:0]  left   [ACTOR_COUNT];
    logic [FIRED_W-1:0] fired  [ACTOR_COUNT];
    fire_result_t       expected_firings[$];
    int                 errors;
    int                 requests;
    int                 checked;
    int                 status_seen[4];

    function new();
      for (int e = 0; e < EDGE_COUNT; e++) begin
        desc[e]   = EDGE_DESC_RESET[e];
        tokens[e] = '0;
      end
      for (int a = 0; a < ACTOR_COUNT; a++) begin
        left[a]  = '0;
        fired[a] = '0;
      end
      reps = REPS_RESET;
    endfunction

    function void write_reg(int idx, logic [63:0] value);
      if (idx < EDGE_COUNT) desc[idx] = value[DESC_W-1:0];
      else if (idx == REG_REPEAT) reps = value[REPS_W-1:0];
    endfunction

    function bit ready_to_fire(int a);
      if (left[a] == 0) return 1'b0;
      for (int e = 0; e < EDGE_COUNT; e++)
        if (desc[e][5:3] == a && tokens[e] < desc[e][13:10]) return 1'b0;
      return 1'b1;
    endfunction

    function void note_request(logic want_restart);
      fire_result_t r;
      bit           any_left;
      bit           done;
      int           q;
      int           t;
      r = '0;
      requests++;
      if (want_restart) begin
        for (int e = 0; e < EDGE_COUNT; e++) tokens[e] = '0;
        for (int a = 0; a < ACTOR_COUNT; a++) begin
          q = int'(reps[REP_FIELD_W*a +: REP_FIELD_W]);
          if (q > MAX_REPEAT) q = MAX_REPEAT;
          left[a]  = LEFT_W'(q);
          fired[a] = '0;
        end
        r.status = ST_RESTART;
      end else begin
        any_left = 1'b0;
        for (int a = 0; a < ACTOR_COUNT; a++)
          if (left[a] != 0) any_left = 1'b1;
        if (!any_left) begin
          r.status = ST_COMPLETE;
        end else begin
          r.status = ST_BLOCKED;
          done = 1'b0;
          // downstream first: highest-numbered enabled actor wins
          for (int a = ACTOR_COUNT - 1; a >= 0 && !done; a--) begin
            if (ready_to_fire(a)) begin
              // consume before produce so a self loop sees its own tokens
              for (int e = 0; e < EDGE_COUNT; e++)
                if (desc[e][5:3] == a) tokens[e] = tokens[e] - desc[e][13:10];
              for (int e = 0; e < EDGE_COUNT; e++)
                if (desc[e][2:0] == a) begin
                  t = tokens[e] + desc[e][9:6];
                  tokens[e] = (t > 255) ? 8'd255 : t[7:0];
                end
              r.status       = ST_FIRED;
              r.actor        = ACTOR_W'(a);
              r.firing_index = fired[a];
              fired[a]       = fired[a] + 1'b1;
              left[a]        = left[a] - 1'b1;
              done           = 1'b1;
            end
          end
        end
      end
      expected_firings.push_back(r);
    endfunction

    task report_mismatch(string what);
      $display("[%0t] MISMATCH: %s", $time, what);
      errors++;
    endtask

    task check_firing(logic [1:0] st, logic [2:0] actor, logic [3:0] idx);
      fire_result_t exp;
      if (expected_firings.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending, status %0d", st));
        return;
      end
      exp = expected_firings.pop_front();
      checked++;
      status_seen[int'(exp.status)]++;
      if (st !== exp.status)
        report_mismatch($sformatf("status %0d, want %0d", st, exp.status));
      if (actor !== exp.actor)
        report_mismatch($sformatf("actor %0d, want %0d", actor, exp.actor));
      if (idx !== exp.firing_index)
        report_mismatch($sformatf("firing index %0d, want %0d", idx, exp.firing_index));
    endtask
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic        restart_i   = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [2:0]  actor_o;
  logic [3:0]  firing_index_o;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [5:0]  paddr       = '0;
  logic [63:0] pwdata      = '0;
  logic [63:0] prdata;
  logic        pready;

  firing_scoreboard sb = new();
  int idle_pct  = 0;
  int stall_pct = 0;
  int graphs    = 0;

  dataflow_firing_scheduler_core dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .restart_i,
    .out_valid_o, .out_stall_i, .status_o, .actor_o, .firing_index_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) out_stall_i <= ($urandom_range(99) < stall_pct);

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_request(restart_i);
      if (out_valid_o && !out_stall_i)
        sb.check_firing(status_o, actor_o, firing_index_o);
    end
  end

  function automatic logic [DESC_W-1:0] desc_of(int src, int dst, int prod, int cons);
    return {4'(cons), 4'(prod), 3'(dst), 3'(src)};
  endfunction

  function automatic logic [REPS_W-1:0] pack_reps(input logic [4:0] q [ACTOR_COUNT]);
    logic [REPS_W-1:0] v;
    v = '0;
    for (int a = 0; a < ACTOR_COUNT; a++) v[REP_FIELD_W*a +: REP_FIELD_W] = q[a];
    return v;
  endfunction

  task automatic send_request(input bit want_restart);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      restart_i  <= 1'($urandom_range(1));
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    restart_i  <= want_restart;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Drop valid and wait until every pending result has been taken.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_firings.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic reg_write(input int idx, input logic [63:0] value);
    int width;
    width   = (idx == REG_REPEAT) ? REPS_W : DESC_W;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 6'(idx * 8);
    // junk above the register width must be dropped
    pwdata  <= ({$urandom, $urandom} << width) | value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.write_reg(idx, value);
    @(posedge clk_i);
  endtask

  task automatic reg_check(input int idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= 6'(idx * 8);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == REG_REPEAT) begin
      if (prdata[REPS_W-1:0] !== sb.reps)
        sb.report_mismatch($sformatf("repeat register reads %0h", prdata));
    end else if (prdata[DESC_W-1:0] !== sb.desc[idx]) begin
      sb.report_mismatch($sformatf("edge register %0d reads %0h", idx, prdata));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_graph(input logic [DESC_W-1:0] d [EDGE_COUNT],
                            input logic [4:0] q [ACTOR_COUNT]);
    for (int e = 0; e < EDGE_COUNT; e++) reg_write(e, d[e]);
    reg_write(REG_REPEAT, pack_reps(q));
    for (int e = 0; e < EDGE_COUNT; e++) reg_check(e);
    reg_check(REG_REPEAT);
    graphs++;
  endtask

  task automatic run_random_graph();
    logic [4:0]        q [ACTOR_COUNT];
    logic [DESC_W-1:0] d [EDGE_COUNT];
    int                used;
    int                s;
    int                t;
    int                total;
    bit                noisy;
    noisy = ($urandom_range(99) < 20);
    total = 0;
    for (int a = 0; a < ACTOR_COUNT; a++) begin
      q[a] = ($urandom_range(99) < 10) ? 5'($urandom_range(5, 31))
                                       : 5'($urandom_range(0, 4));
      total += (q[a] > MAX_REPEAT) ? MAX_REPEAT : q[a];
    end
    used = $urandom_range(1, EDGE_COUNT);
    for (int e = 0; e < EDGE_COUNT; e++) begin
      if (noisy) begin
        d[e] = DESC_W'($urandom_range(0, 16383));
      end else if (e < used) begin
        // balanced rates: q[src] * prod == q[dst] * cons
        s    = $urandom_range(0, ACTOR_COUNT - 2);
        t    = $urandom_range(s + 1, ACTOR_COUNT - 1);
        d[e] = desc_of(s, t, (q[t] > 15) ? 15 : q[t], (q[s] > 15) ? 15 : q[s]);
      end else begin
        d[e] = desc_of($urandom_range(7), $urandom_range(7), 0, 0);
      end
    end
    load_graph(d, q);
    repeat ($urandom_range(1, 2)) begin
      send_request(1'b1);
      repeat (total + 2) send_request($urandom_range(99) < 4);
    end
    drain();
  endtask

  initial begin
    logic [DESC_W-1:0] d [EDGE_COUNT];
    logic [4:0]        q [ACTOR_COUNT];
    int                start;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_pct  = 27;
    stall_pct = 80;

    // out of reset nothing is loaded: complete until the first restart
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    repeat (4) send_request(1'b0);
    drain();

    // mutual deadlock between 0 and 1, self loop on 5, chain 7 -> 6,
    // zero consume rate into 7
    d[0] = desc_of(1, 0, 1, 1);
    d[1] = desc_of(0, 1, 1, 1);
    d[2] = desc_of(5, 5, 15, 0);
    d[3] = desc_of(7, 6, 3, 2);
    d[4] = desc_of(2, 7, 4, 0);
    d[5] = desc_of(0, 0, 0, 0);
    d[6] = desc_of(0, 0, 0, 0);
    q    = '{1, 1, 0, 0, 0, 2, 3, 2};
    load_graph(d, q);
    send_request(1'b1);
    repeat (9) send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
    drain();

    // no firings at all: restart then complete at once
    q = '{0, 0, 0, 0, 0, 0, 0, 0};
    reg_write(REG_REPEAT, pack_reps(q));
    send_request(1'b1);
    send_request(1'b0);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          idle_pct  = 27;
          stall_pct = 80;
        end
        1: begin
          idle_pct  = 80;
          stall_pct = 27;
        end
        default: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
      endcase
      start = sb.requests;
      while (sb.requests - start < 150) run_random_graph();
    end

    drain();
    $display("Covered %0d requests over %0d graph settings in three handshake mixes.",
             sb.requests, graphs);
    $display("Results: %0d fired, %0d blocked, %0d complete, %0d restart.",
             sb.status_seen[ST_FIRED], sb.status_seen[ST_BLOCKED],
             sb.status_seen[ST_COMPLETE], sb.status_seen[ST_RESTART]);
    if (sb.errors == 0) begin
      $display("tb_dataflow_firing_scheduler_core: done, clean");
    end else begin
      $display("tb_dataflow_firing_scheduler_core: done, errors");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("[%0t] timeout", $time);
    $display("tb_dataflow_firing_scheduler_core: done, errors");
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/dfs_pkg.sv
hw/rtl/dfs_fire_unit.sv
hw/rtl/dataflow_firing_scheduler_core.sv
tb/tb_dataflow_firing_scheduler_core.sv
